// ----- src/assert_macros.svh -----
// Assertion helpers for the framer core. Every use names its own label,
// clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("invariant violated");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- src/crcbf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package crcbf_pkg;

	localparam int REG_AW      = 5;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW     = $clog2(FIFO_DEPTH + 1);

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_MSB  = 16'h8000;
	localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

	localparam logic [2:0] REG_START_FIRST  = 3'd0;
	localparam logic [2:0] REG_START_SECOND = 3'd1;
	localparam logic [2:0] REG_END_FIRST    = 3'd2;
	localparam logic [2:0] REG_END_SECOND   = 3'd3;
	localparam logic [2:0] REG_MAX_LEN      = 3'd4;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] frame_len;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       frame_done;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [7:0]  start_byte_first;
		logic [7:0]  start_byte_second;
		logic [7:0]  end_byte_first;
		logic [7:0]  end_byte_second;
		logic [15:0] max_payload_len;
	} cfg_t;

	// One classified payload byte on its way to the emitter.
	typedef struct packed {
		logic        first;
		logic        last;
		logic [7:0]  data_byte;
		logic [15:0] frame_len;
		logic [15:0] crc;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// CRC-16/CCITT-FALSE update by one byte, MSB first.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
			input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- src/crcbf_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module crcbf_regs import crcbf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [REG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output cfg_t                   cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign reg_idx = paddr[REG_AW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte_first  <= 8'h00;
			cfg_q.start_byte_second <= 8'h00;
			cfg_q.end_byte_first    <= 8'h00;
			cfg_q.end_byte_second   <= 8'h00;
			cfg_q.max_payload_len   <= MAX_LEN_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				REG_START_FIRST:  cfg_q.start_byte_first  <= pwdata[7:0];
				REG_START_SECOND: cfg_q.start_byte_second <= pwdata[7:0];
				REG_END_FIRST:    cfg_q.end_byte_first    <= pwdata[7:0];
				REG_END_SECOND:   cfg_q.end_byte_second   <= pwdata[7:0];
				REG_MAX_LEN:      cfg_q.max_payload_len   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_START_FIRST:  prdata = {24'h0, cfg_q.start_byte_first};
			REG_START_SECOND: prdata = {24'h0, cfg_q.start_byte_second};
			REG_END_FIRST:    prdata = {24'h0, cfg_q.end_byte_first};
			REG_END_SECOND:   prdata = {24'h0, cfg_q.end_byte_second};
			REG_MAX_LEN:      prdata = {16'h0, cfg_q.max_payload_len};
			default:          prdata = 32'h0;
		endcase
	end

endmodule

`default_nettype wire

// ----- src/crcbf_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crcbf_front import crcbf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  item_t      item,
	input  wire logic [15:0] max_payload_len,
	input  fifo_stat_t fifo_stat,
	output logic       push,
	output cmd_t       push_cmd
);

	logic        in_frame_q;
	logic        discarding_q;
	logic [15:0] bytes_left_q;
	logic [15:0] crc_q;

	logic        accept;
	logic        start;
	logic        drop_zero;
	logic        disc;
	logic [15:0] len;
	logic [15:0] left_next;
	logic [15:0] crc_next;

	assign item_stall = fifo_stat.full;
	assign accept     = item_valid && !fifo_stat.full;

	always_comb begin
		start     = !in_frame_q;
		len       = start ? item.frame_len : bytes_left_q;
		drop_zero = start && (item.frame_len == 16'h0000);
		disc      = start ? (item.frame_len > max_payload_len) : discarding_q;
		left_next = len - 16'd1;
		crc_next  = crc16_byte(start ? CRC_INIT : crc_q, item.data_byte);
	end

	assign push               = accept && !drop_zero && !disc;
	assign push_cmd.first     = start;
	assign push_cmd.last      = (left_next == 16'h0000);
	assign push_cmd.data_byte = item.data_byte;
	assign push_cmd.frame_len = item.frame_len;
	assign push_cmd.crc       = crc_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			discarding_q <= 1'b0;
			bytes_left_q <= 16'h0000;
			crc_q        <= CRC_INIT;
		end else if (accept && !drop_zero) begin
			in_frame_q   <= (left_next != 16'h0000);
			discarding_q <= disc && (left_next != 16'h0000);
			bytes_left_q <= left_next;
			if (!disc) begin
				crc_q <= crc_next;
			end
		end
	end

	`ASSERT_IMPLY(a_disc_in_frame, clk, arst_n, discarding_q, in_frame_q)

endmodule

`default_nettype wire

// ----- src/crcbf_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crcbf_fifo import crcbf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      push_cmd,
	input  wire logic pop,
	output cmd_t      head,
	output fifo_stat_t stat
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] count_q;

	assign stat.full  = (count_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_ALWAYS(a_no_overflow, clk, arst_n, !(push && stat.full))
	`ASSERT_ALWAYS(a_no_underflow, clk, arst_n, !(pop && stat.empty))

endmodule

`default_nettype wire

// ----- src/crcbf_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module crcbf_back import crcbf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  cfg_t      cfg,
	input  cmd_t      head,
	input  fifo_stat_t fifo_stat,
	output logic      pop,
	output logic      result_valid,
	input  wire logic result_stall,
	output result_t   result
);

	typedef enum logic [8:0] {
		STEP_SOF1   = 9'b0_0000_0001,
		STEP_SOF2   = 9'b0_0000_0010,
		STEP_LEN_LO = 9'b0_0000_0100,
		STEP_LEN_HI = 9'b0_0000_1000,
		STEP_DATA   = 9'b0_0001_0000,
		STEP_CRC_LO = 9'b0_0010_0000,
		STEP_CRC_HI = 9'b0_0100_0000,
		STEP_EOF1   = 9'b0_1000_0000,
		STEP_EOF2   = 9'b1_0000_0000
	} step_t;

	logic       started_q;
	step_t      step_q;
	logic       result_valid_q;
	result_t    result_q;

	logic       can_emit;
	logic       emit;
	step_t      step;
	step_t      step_nxt;
	step_t      end_step;
	result_t    nxt;

	assign can_emit = !result_valid_q || !result_stall;
	assign emit     = can_emit && !fifo_stat.empty;

	always_comb begin
		step     = started_q ? step_q : (head.first ? STEP_SOF1 : STEP_DATA);
		end_step = head.last ? STEP_EOF2 : STEP_DATA;
		nxt.frame_done = 1'b0;
		nxt.run_last   = (step == end_step);
		case (step)
			STEP_SOF1:   nxt.out_byte = cfg.start_byte_first;
			STEP_SOF2:   nxt.out_byte = cfg.start_byte_second;
			STEP_LEN_LO: nxt.out_byte = head.frame_len[7:0];
			STEP_LEN_HI: nxt.out_byte = head.frame_len[15:8];
			STEP_DATA:   nxt.out_byte = head.data_byte;
			STEP_CRC_LO: nxt.out_byte = head.crc[7:0];
			STEP_CRC_HI: nxt.out_byte = head.crc[15:8];
			STEP_EOF1:   nxt.out_byte = cfg.end_byte_first;
			STEP_EOF2: begin
				nxt.out_byte   = cfg.end_byte_second;
				nxt.frame_done = 1'b1;
			end
			default:     nxt.out_byte = 8'h00;
		endcase
		case (step)
			STEP_SOF1:   step_nxt = STEP_SOF2;
			STEP_SOF2:   step_nxt = STEP_LEN_LO;
			STEP_LEN_LO: step_nxt = STEP_LEN_HI;
			STEP_LEN_HI: step_nxt = STEP_DATA;
			STEP_DATA:   step_nxt = STEP_CRC_LO;
			STEP_CRC_LO: step_nxt = STEP_CRC_HI;
			STEP_CRC_HI: step_nxt = STEP_EOF1;
			STEP_EOF1:   step_nxt = STEP_EOF2;
			default:     step_nxt = STEP_SOF1;
		endcase
	end

	assign pop = emit && (step == end_step);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q      <= 1'b0;
			step_q         <= STEP_SOF1;
			result_valid_q <= 1'b0;
		end else begin
			if (can_emit) begin
				result_valid_q <= emit;
			end
			if (emit) begin
				started_q <= (step != end_step);
				step_q    <= step_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q <= nxt;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`ASSERT_IMPLY(a_head_held, clk, arst_n, started_q, !fifo_stat.empty)

endmodule

`default_nettype wire

// ----- src/crc16_byte_framer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Byte framer with CRC-16/CCITT-FALSE trailer.
// Input channel (item_valid, item_stall, item) carries one payload byte per
// transaction; frame_len is sampled only on the first byte of a frame. Each
// accepted frame comes out on the result channel as two start bytes, the
// length (low byte first), the payload, the CRC (low byte first) and two end
// bytes; frame_done marks the second end byte, run_last the final byte caused
// by one input transaction. Frames of length zero, or longer than
// max_payload_len, are consumed and produce nothing.
// An accepted item is written into the queue, then its first result into the
// output register. Throughput: one result per cycle while the queue holds
// entries and the receiver does not stall. A middle byte yields its data byte
// alone, a frame's first byte also the start bytes and length, its last byte
// also the CRC and end bytes. The output register is the limit; a four-entry
// queue between the classifier and the emitter lets input keep flowing while
// a header or trailer drains. When the receiver stalls, the output register
// holds its byte and the queue fills; item_stall rises once the queue is full.
// Reset clears the frame state, empties the queue and restores the register
// defaults (markers zero, maximum length 65535). The register port writes
// with psel, penable and pwrite high; pready is always high.

module crc16_byte_framer_core import crcbf_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [REG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  item_t                  item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output result_t                result
);

	cfg_t       cfg;
	fifo_stat_t fifo_stat;
	logic       push;
	logic       pop;
	cmd_t       push_cmd;
	cmd_t       head;

	// Zero wait-state register port.
	assign pready = 1'b1;

	crcbf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	// Front end: tracks the frame, drops rejected bytes and runs the CRC.
	crcbf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_stall      (item_stall),
		.item            (item),
		.max_payload_len (cfg.max_payload_len),
		.fifo_stat       (fifo_stat),
		.push            (push),
		.push_cmd        (push_cmd)
	);

	crcbf_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (fifo_stat)
	);

	// Back end: expands queued bytes into the header, data and trailer of a frame.
	crcbf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.fifo_stat    (fifo_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire
